/* rtl/lineb_pkg.sv */
package lineb_pkg;

    localparam int MIN_COL   = 2;
    localparam int MAX_COL   = 66;
    localparam int TAB_WIDTH = 5;
    localparam int TAB_MARGIN = 2;
    localparam int LINE_CAP  = 64;
    localparam int POS_W     = $clog2(LINE_CAP);

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // key command codes
    localparam logic [3:0] KIND_INS   = 4'd0;
    localparam logic [3:0] KIND_BS    = 4'd1;
    localparam logic [3:0] KIND_DEL   = 4'd2;
    localparam logic [3:0] KIND_TAB   = 4'd3;
    localparam logic [3:0] KIND_LEFT  = 4'd4;
    localparam logic [3:0] KIND_RIGHT = 4'd5;
    localparam logic [3:0] KIND_HOME  = 4'd6;
    localparam logic [3:0] KIND_END   = 4'd7;
    localparam logic [3:0] KIND_ENTER = 4'd8;

    // per-cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_SHL  = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        logic [7:0]       ch;
    } t_cell_ctl;

    typedef struct packed {
        logic        accepted;
        logic [6:0]  cursor_col;
        logic [6:0]  line_length;
        logic [15:0] line_number;
        logic        char_valid;
        logic [7:0]  char_out;
        logic        last;
    } t_res;

endpackage

/* rtl/lineb_if.sv */
interface lineb_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] char_in;

    modport source (output valid, kind, char_in, input ready);
    modport sink   (input valid, kind, char_in, output ready);
endinterface

interface lineb_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [6:0]  cursor_col;
    logic [6:0]  line_length;
    logic [15:0] line_number;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        last;

    modport source (output valid, accepted, cursor_col, line_length, line_number,
                    char_valid, char_out, last, input ready);
    modport sink   (input valid, accepted, cursor_col, line_length, line_number,
                    char_valid, char_out, last, output ready);
endinterface

/* rtl/lineb_cell.sv */
module lineb_cell (
    input  logic                         i_clk,
    input  lineb_pkg::t_cell_ctl         i_ctl,
    input  logic [lineb_pkg::POS_W-1:0]  i_idx,
    input  logic [7:0]                   i_left,
    input  logic [7:0]                   i_right,
    output logic [7:0]                   o_data
);

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            lineb_pkg::CELL_INS: begin
                // open a gap: take the left neighbour above the cursor
                if (i_idx > i_ctl.pos) begin
                    n_data = i_left;
                end else if (i_idx == i_ctl.pos) begin
                    n_data = i_ctl.ch;
                end
            end
            lineb_pkg::CELL_DEL: begin
                if (i_idx >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            lineb_pkg::CELL_SHL: n_data = i_right;
            default:             n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/line_edit_buffer.sv */
// Single-step status results are registered on acceptance. Tab inserts TAB_WIDTH spaces
// by the cell row, one per cycle (the last waits for output room), then reports. Enter
// drains the line from cell 0, one character item per cycle while output has room.
// Throughput: one single-step command item per cycle while results are taken; the cell
// row serves one command at a time. Reset (synchronous, active low) puts the cursor at
// the prompt column and clears length and line count; cells hold undefined data.
module line_edit_buffer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lineb_cmd_if.sink          i_cmd,
    lineb_res_if.source        o_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TAB   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [7:0] MIN_COL_8  = 8'(lineb_pkg::MIN_COL);
    localparam logic [7:0] MAX_COL_8  = 8'(lineb_pkg::MAX_COL);
    localparam logic [7:0] TAB_8      = 8'(lineb_pkg::TAB_WIDTH);
    localparam logic [7:0] CAP_8      = 8'(lineb_pkg::LINE_CAP);
    localparam logic [7:0] TAB_LIM_8  = 8'(lineb_pkg::MAX_COL - lineb_pkg::TAB_WIDTH);
    localparam logic [7:0] TAB_ROOM_8 = 8'(lineb_pkg::MAX_COL - lineb_pkg::TAB_MARGIN);
    localparam logic [6:0] MIN_COL_7  = 7'(lineb_pkg::MIN_COL);
    localparam logic [6:0] TAB_7      = 7'(lineb_pkg::TAB_WIDTH);
    localparam logic [7:0] SPACE_CHAR_W = lineb_pkg::SPACE_CHAR;

    logic [1:0]  r_state,  n_state;
    logic [6:0]  r_cursor, n_cursor;
    logic [6:0]  r_length, n_length;
    logic [15:0] r_lines,  n_lines;
    logic [6:0]  r_cnt,    n_cnt;
    lineb_pkg::t_res r_res, n_res;
    logic        r_res_valid;

    lineb_pkg::t_cell_ctl cell_ctl;
    logic [7:0]  cell_data [lineb_pkg::LINE_CAP];

    logic        out_free;
    logic        accept;
    logic        emit;
    logic        acc;
    logic        ch_valid;
    logic [7:0]  ch_out;
    logic        fin;
    logic [6:0]  pos;
    logic [7:0]  cur8;
    logic [7:0] len8;

    // the output register frees when empty or being taken
    assign out_free    = !r_res_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && out_free;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // cursor always sits at or beyond the prompt, so this never underflows
    assign pos  = r_cursor - MIN_COL_7;
    assign cur8 = {1'b0, r_cursor};
    assign len8 = {1'b0, r_length};

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_length = r_length;
        n_lines  = r_lines;
        n_cnt    = r_cnt;
        emit     = 1'b0;
        acc      = 1'b0;
        ch_valid = 1'b0;
        ch_out   = 8'd0;
        fin      = 1'b1;
        cell_ctl.op  = lineb_pkg::CELL_HOLD;
        cell_ctl.pos = pos[lineb_pkg::POS_W-1:0];
        cell_ctl.ch  = i_cmd.char_in;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    emit = 1'b1;
                    case (i_cmd.kind)
                        lineb_pkg::KIND_INS: begin
                            if (cur8 < MAX_COL_8 && len8 + MIN_COL_8 < MAX_COL_8
                                && len8 < CAP_8) begin
                                cell_ctl.op = lineb_pkg::CELL_INS;
                                n_length    = r_length + 7'd1;
                                n_cursor    = r_cursor + 7'd1;
                                acc         = 1'b1;
                            end
                        end
                        lineb_pkg::KIND_BS: begin
                            if (r_length != 7'd0 && r_cursor > MIN_COL_7) begin
                                // close the gap over the character before the cursor
                                cell_ctl.op  = lineb_pkg::CELL_DEL;
                                cell_ctl.pos = lineb_pkg::POS_W'(pos - 7'd1);
                                n_length     = r_length - 7'd1;
                                n_cursor     = r_cursor - 7'd1;
                                acc          = 1'b1;
                            end
                        end
                        lineb_pkg::KIND_DEL: begin
                            if (r_length != 7'd0 && cur8 < len8 + MIN_COL_8) begin
                                cell_ctl.op = lineb_pkg::CELL_DEL;
                                n_length    = r_length - 7'd1;
                                acc         = 1'b1;
                            end
                        end
                        lineb_pkg::KIND_TAB: begin
                            if (cur8 <= TAB_LIM_8 && len8 + TAB_8 <= TAB_ROOM_8
                                && len8 + TAB_8 <= CAP_8) begin
                                // hold the result until the last space is in
                                emit    = 1'b0;
                                n_state = ST_TAB;
                                n_cnt   = TAB_7;
                            end
                        end
                        lineb_pkg::KIND_LEFT: begin
                            if (r_cursor > MIN_COL_7) begin
                                n_cursor = r_cursor - 7'd1;
                                acc      = 1'b1;
                            end
                        end
                        lineb_pkg::KIND_RIGHT: begin
                            if (cur8 < len8 + MIN_COL_8) begin
                                n_cursor = r_cursor + 7'd1;
                                acc      = 1'b1;
                            end
                        end
                        lineb_pkg::KIND_HOME: begin
                            n_cursor = MIN_COL_7;
                            acc      = (r_cursor != MIN_COL_7);
                        end
                        lineb_pkg::KIND_END: begin
                            n_cursor = r_length + MIN_COL_7;
                            acc      = (r_cursor != n_cursor);
                        end
                        lineb_pkg::KIND_ENTER: begin
                            n_length = 7'd0;
                            n_cursor = MIN_COL_7;
                            n_lines  = r_lines + 16'd1;
                            acc      = 1'b1;
                            if (r_length != 7'd0) begin
                                // drain the line one character item per cycle while the output register has room
                                emit    = 1'b0;
                                n_state = ST_DRAIN;
                                n_cnt   = r_length;
                            end
                        end
                        default: acc = 1'b0;
                    endcase
                end
            end
            ST_TAB: begin
                // the final space waits for room in the output register
                if (r_cnt != 7'd1 || out_free) begin
                    cell_ctl.op = lineb_pkg::CELL_INS;
                    cell_ctl.ch = SPACE_CHAR_W;
                    n_length    = r_length + 7'd1;
                    n_cursor    = r_cursor + 7'd1;
                    n_cnt       = r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        emit    = 1'b1;
                        acc     = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    // send cell 0 and advance the row one place
                    cell_ctl.op = lineb_pkg::CELL_SHL;
                    emit        = 1'b1;
                    acc         = 1'b1;
                    ch_valid    = 1'b1;
                    ch_out      = cell_data[0];
                    fin         = (r_cnt == 7'd1);
                    n_cnt       = r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_res.accepted    = acc;
        n_res.cursor_col  = n_cursor;
        n_res.line_length = n_length;
        n_res.line_number = n_lines;
        n_res.char_valid  = ch_valid;
        n_res.char_out    = ch_out;
        n_res.last        = fin;
    end

    // row of character cells, each fed by both neighbours
    for (genvar g = 0; g < lineb_pkg::LINE_CAP; g++) begin : g_cell
        logic [7:0] left_d;
        logic [7:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = 8'd0;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == lineb_pkg::LINE_CAP - 1) begin : g_end
            assign right_d = 8'd0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        lineb_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_idx   (lineb_pkg::POS_W'(g)),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= MIN_COL_7;
            r_length    <= 7'd0;
            r_lines     <= 16'd0;
            r_cnt       <= 7'd0;
            r_res_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_length <= n_length;
            r_lines  <= n_lines;
            r_cnt    <= n_cnt;
            if (emit) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // hold the result payload until the next emission
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.accepted    = r_res.accepted;
    assign o_res.cursor_col  = r_res.cursor_col;
    assign o_res.line_length = r_res.line_length;
    assign o_res.line_number = r_res.line_number;
    assign o_res.char_valid  = r_res.char_valid;
    assign o_res.char_out    = r_res.char_out;
    assign o_res.last        = r_res.last;

endmodule

/* sim/line_edit_buffer_tb.sv */
`timescale 1ns / 1ps

module line_edit_buffer_tb;

    // command codes above enter do nothing but report
    localparam logic [3:0] KIND_SPARE_LO = lineb_pkg::KIND_ENTER + 4'd1;
    localparam logic [3:0] KIND_SPARE_HI = 4'hF;
    localparam int RANDOM_KEYS = 270;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [3:0] kind;
        logic [7:0] ch;
    } t_key_item;

    logic i_clk;
    logic i_rst_n;

    lineb_cmd_if cmd_if ();
    lineb_res_if res_if ();

    line_edit_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // keys waiting to be sent, and status / character items still owed by the block
    t_key_item       pending_keys[$];
    lineb_pkg::t_res expected_results[$];
    int        key_total;
    int        keys_taken;
    int        mismatches;

    // predicted edit state
    logic [7:0]  line_text [lineb_pkg::LINE_CAP];
    logic [6:0]  edit_col = 7'(lineb_pkg::MIN_COL);
    logic [6:0]  edit_len = '0;
    logic [15:0] lines_ended = '0;

    // idle control for both sides
    int        tx_idle_left;
    int        tx_smooth_left;
    int        rx_stall_left;
    int        rx_smooth_left;
    t_key_item next_key;
    lineb_pkg::t_res want;

    always #5 i_clk = ~i_clk;

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.kind    = lineb_pkg::KIND_INS;
        cmd_if.char_in = 8'h00;
        res_if.ready   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // queue one result carrying the state as it stands now
    function automatic void owe_result(input logic acc, input logic cv,
                                       input logic [7:0] ch, input logic fin);
        lineb_pkg::t_res r;
        r.accepted    = acc;
        r.cursor_col  = edit_col;
        r.line_length = edit_len;
        r.line_number = lines_ended;
        r.char_valid  = cv;
        r.char_out    = ch;
        r.last        = fin;
        expected_results.push_back(r);
    endfunction

    // apply one key to the predicted line and owe whatever it produces
    function automatic void apply_key(input logic [3:0] kind, input logic [7:0] ch);
        int   pos;
        int   i;
        int   old_len;
        logic took;
        pos  = int'(edit_col) - lineb_pkg::MIN_COL;
        took = 1'b0;
        case (kind)
            lineb_pkg::KIND_INS: begin
                // refuse when the cursor is at the right margin or the store is full
                if (edit_col < lineb_pkg::MAX_COL
                        && edit_len + lineb_pkg::MIN_COL < lineb_pkg::MAX_COL
                        && edit_len < lineb_pkg::LINE_CAP) begin
                    for (i = int'(edit_len); i > pos; i--)
                        line_text[i] = line_text[i-1];
                    line_text[pos] = ch;
                    edit_len++;
                    edit_col++;
                    took = 1'b1;
                end
            end
            lineb_pkg::KIND_BS: begin
                // close the gap left of the cursor
                if (edit_len != 0 && edit_col > lineb_pkg::MIN_COL) begin
                    for (i = pos - 1; i + 1 < int'(edit_len); i++)
                        line_text[i] = line_text[i+1];
                    edit_len--;
                    edit_col--;
                    took = 1'b1;
                end
            end
            lineb_pkg::KIND_DEL: begin
                // close the gap under the cursor; the cursor stays put
                if (edit_len != 0 && edit_col < edit_len + lineb_pkg::MIN_COL) begin
                    for (i = pos; i + 1 < int'(edit_len); i++)
                        line_text[i] = line_text[i+1];
                    edit_len--;
                    took = 1'b1;
                end
            end
            lineb_pkg::KIND_TAB: begin
                // all spaces or none: check column, margin and store room
                if (edit_col <= lineb_pkg::MAX_COL - lineb_pkg::TAB_WIDTH
                        && edit_len + lineb_pkg::TAB_WIDTH
                           <= lineb_pkg::MAX_COL - lineb_pkg::TAB_MARGIN
                        && edit_len + lineb_pkg::TAB_WIDTH <= lineb_pkg::LINE_CAP) begin
                    for (i = int'(edit_len) - 1; i >= pos; i--)
                        line_text[i+lineb_pkg::TAB_WIDTH] = line_text[i];
                    for (i = 0; i < lineb_pkg::TAB_WIDTH; i++)
                        line_text[pos+i] = lineb_pkg::SPACE_CHAR;
                    edit_len += 7'(lineb_pkg::TAB_WIDTH);
                    edit_col += 7'(lineb_pkg::TAB_WIDTH);
                    took = 1'b1;
                end
            end
            lineb_pkg::KIND_LEFT: begin
                if (edit_col > lineb_pkg::MIN_COL) begin
                    edit_col--;
                    took = 1'b1;
                end
            end
            lineb_pkg::KIND_RIGHT: begin
                if (edit_col < edit_len + lineb_pkg::MIN_COL) begin
                    edit_col++;
                    took = 1'b1;
                end
            end
            lineb_pkg::KIND_HOME: begin
                took     = (edit_col != lineb_pkg::MIN_COL);
                edit_col = 7'(lineb_pkg::MIN_COL);
            end
            lineb_pkg::KIND_END: begin
                took     = (edit_col != edit_len + lineb_pkg::MIN_COL);
                edit_col = edit_len + 7'(lineb_pkg::MIN_COL);
            end
            lineb_pkg::KIND_ENTER: begin
                // clear first: every drained item shows the state after the enter
                old_len     = int'(edit_len);
                edit_len    = '0;
                edit_col    = 7'(lineb_pkg::MIN_COL);
                lines_ended = lines_ended + 16'd1;
                if (old_len == 0) begin
                    owe_result(1'b1, 1'b0, 8'h00, 1'b1);
                end else begin
                    for (i = 0; i < old_len; i++)
                        owe_result(1'b1, 1'b1, line_text[i], i == old_len - 1);
                end
                return;
            end
            default: ;
        endcase
        owe_result(took, 1'b0, 8'h00, 1'b1);
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic void push_key(input logic [3:0] kind, input logic [7:0] ch);
        t_key_item k;
        k.kind = kind;
        k.ch   = ch;
        pending_keys.push_back(k);
    endfunction

    // one plausible keystroke, weighted towards typing
    function automatic void push_random_edit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)      push_key(lineb_pkg::KIND_INS, 8'($urandom));
        else if (r < 58) push_key(lineb_pkg::KIND_TAB, 8'($urandom));
        else if (r < 66) push_key(lineb_pkg::KIND_BS, 8'($urandom));
        else if (r < 74) push_key(lineb_pkg::KIND_DEL, 8'($urandom));
        else if (r < 80) push_key(lineb_pkg::KIND_LEFT, 8'($urandom));
        else if (r < 86) push_key(lineb_pkg::KIND_RIGHT, 8'($urandom));
        else if (r < 90) push_key(lineb_pkg::KIND_HOME, 8'($urandom));
        else if (r < 94) push_key(lineb_pkg::KIND_END, 8'($urandom));
        else if (r < 97)
            push_key(4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 8'($urandom));
        else             push_key(lineb_pkg::KIND_ENTER, 8'($urandom));
    endfunction

    // gap length: mostly none, some short, a few long, with calm stretches
    function automatic int next_idle(inout int smooth_left);
        int r;
        if (smooth_left > 0) begin
            smooth_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            smooth_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // ---------------------------------------------------------------------
    // Key driver
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                apply_key(cmd_if.kind, cmd_if.char_in);
                keys_taken++;
            end
            // advance only when the current item has gone or none is offered
            if (!cmd_if.valid || cmd_if.ready) begin
                if (tx_idle_left > 0) begin
                    tx_idle_left--;
                    cmd_if.valid <= 1'b0;
                end else if (pending_keys.size() > 0) begin
                    next_key        = pending_keys.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.kind    <= next_key.kind;
                    cmd_if.char_in <= next_key.ch;
                    tx_idle_left    = next_idle(tx_smooth_left);
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    endtask

    task automatic check_field(input string what, input int unsigned got,
                               input int unsigned exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result item, cursor_col",
                                    32'(res_if.cursor_col), 0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", 32'(res_if.accepted), 32'(want.accepted));
                    check_field("cursor_col", 32'(res_if.cursor_col),
                                32'(want.cursor_col));
                    check_field("line_length", 32'(res_if.line_length),
                                32'(want.line_length));
                    check_field("line_number", 32'(res_if.line_number),
                                32'(want.line_number));
                    check_field("char_valid", 32'(res_if.char_valid),
                                32'(want.char_valid));
                    check_field("char_out", 32'(res_if.char_out), 32'(want.char_out));
                    check_field("last", 32'(res_if.last), 32'(want.last));
                end
            end
            // hold ready low for a while now and then
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                rx_stall_left = next_idle(rx_smooth_left);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------
    initial begin
        int goal;
        int scenario;
        int n;
        int j;
        int r;
        bit filled_once;

        // directed: empty-line refusals, an empty enter and spare codes first
        push_key(lineb_pkg::KIND_BS, 8'h00);
        push_key(lineb_pkg::KIND_DEL, 8'h00);
        push_key(lineb_pkg::KIND_LEFT, 8'h00);
        push_key(lineb_pkg::KIND_RIGHT, 8'h00);
        push_key(lineb_pkg::KIND_HOME, 8'h00);
        push_key(lineb_pkg::KIND_END, 8'h00);
        push_key(lineb_pkg::KIND_ENTER, 8'h00);
        push_key(KIND_SPARE_LO, 8'hFF);
        push_key(KIND_SPARE_HI, 8'h00);
        // build a short line and edit inside it
        push_key(lineb_pkg::KIND_INS, 8'h00);
        push_key(lineb_pkg::KIND_INS, 8'hFF);
        push_key(lineb_pkg::KIND_TAB, 8'hFF);
        push_key(lineb_pkg::KIND_LEFT, 8'h00);
        push_key(lineb_pkg::KIND_HOME, 8'h00);
        push_key(lineb_pkg::KIND_INS, 8'hA5);
        push_key(lineb_pkg::KIND_DEL, 8'h00);
        push_key(lineb_pkg::KIND_RIGHT, 8'h00);
        push_key(lineb_pkg::KIND_BS, 8'h00);
        push_key(lineb_pkg::KIND_END, 8'h00);
        push_key(lineb_pkg::KIND_DEL, 8'h00);
        push_key(lineb_pkg::KIND_RIGHT, 8'h00);
        push_key(lineb_pkg::KIND_INS, 8'h5A);
        push_key(lineb_pkg::KIND_ENTER, 8'h00);

        // random: mostly editing sessions closed by enter, a few full lines, some noise
        goal        = RANDOM_KEYS;
        filled_once = 1'b0;
        while (pending_keys.size() < goal) begin
            scenario = $urandom_range(0, 99);
            if (!filled_once || scenario < 12) begin
                // type past capacity, then try refusals and edits at a full line
                filled_once = 1'b1;
                for (j = 0; j < 70; j++) begin
                    r = $urandom_range(0, 15);
                    if (r == 0)      push_key(lineb_pkg::KIND_LEFT, 8'($urandom));
                    else if (r == 1) push_key(lineb_pkg::KIND_RIGHT, 8'($urandom));
                    else if (r == 2) push_key(lineb_pkg::KIND_TAB, 8'($urandom));
                    else             push_key(lineb_pkg::KIND_INS, 8'($urandom));
                end
                push_key(lineb_pkg::KIND_END, 8'($urandom));
                push_key(lineb_pkg::KIND_INS, 8'($urandom));
                push_key(lineb_pkg::KIND_TAB, 8'($urandom));
                push_key(lineb_pkg::KIND_HOME, 8'($urandom));
                push_key(lineb_pkg::KIND_INS, 8'($urandom));
                push_key(lineb_pkg::KIND_BS, 8'($urandom));
                push_key(lineb_pkg::KIND_DEL, 8'($urandom));
                push_key(lineb_pkg::KIND_RIGHT, 8'($urandom));
                push_key(lineb_pkg::KIND_BS, 8'($urandom));
                push_key(lineb_pkg::KIND_ENTER, 8'($urandom));
            end else if (scenario < 85) begin
                n = $urandom_range(2, 24);
                for (j = 0; j < n; j++)
                    push_random_edit();
                push_key(lineb_pkg::KIND_ENTER, 8'($urandom));
            end else begin
                n = $urandom_range(1, 6);
                for (j = 0; j < n; j++)
                    push_key(4'($urandom), 8'($urandom));
            end
        end
        key_total = pending_keys.size();

        while (keys_taken != key_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        // allow a late tab or stray item to surface
        repeat (lineb_pkg::TAB_WIDTH + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/lineb_pkg.sv
rtl/lineb_if.sv
rtl/lineb_cell.sv
rtl/line_edit_buffer.sv
sim/line_edit_buffer_tb.sv
